// ----- rtl/mie_pkg.sv -----
// shared types, opcodes and helpers for the i-type execute block
`default_nettype none

package mie_pkg;

  typedef enum logic [3:0] {
    OP_ADDI = 4'd0,
    OP_LW   = 4'd1,
    OP_LH   = 4'd2,
    OP_LHU  = 4'd3,
    OP_LB   = 4'd4,
    OP_LBU  = 4'd5,
    OP_SW   = 4'd6,
    OP_SH   = 4'd7,
    OP_SB   = 4'd8,
    OP_LUI  = 4'd9,
    OP_ANDI = 4'd10,
    OP_ORI  = 4'd11,
    OP_NORI = 4'd12,
    OP_SLTI = 4'd13,
    OP_BEQ  = 4'd14,
    OP_BNE  = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_HOLD
  } state_e;

  // outcome of the execute cycle
  typedef struct packed {
    logic        reg_wr;
    logic [31:0] reg_val;
    logic        ovf;
    logic        aerr;
    logic        merr;
    logic        taken;
    logic [31:0] next_pc;
    logic        load_go;
    logic [3:0]  store_we;
    logic [31:0] store_data;
    logic [31:0] addr;
  } exec_t;

  // one result transaction
  typedef struct packed {
    logic [31:0] next_pc;
    logic        branch_taken;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        overflow_flag;
    logic        address_error;
    logic        misaligned_error;
  } result_t;

  // pick and extend the loaded bytes out of a big-endian memory word
  function automatic logic [31:0] load_extract(op_e op, logic [1:0] off, logic [31:0] word);
    logic [15:0] half;
    logic [7:0]  byte_v;
    logic [31:0] res;
    half = off[1] ? word[15:0] : word[31:16];
    case (off)
      2'd0:    byte_v = word[31:24];
      2'd1:    byte_v = word[23:16];
      2'd2:    byte_v = word[15:8];
      default: byte_v = word[7:0];
    endcase
    case (op)
      OP_LW:   res = word;
      OP_LH:   res = {{16{half[15]}}, half};
      OP_LHU:  res = {16'h0000, half};
      OP_LB:   res = {{24{byte_v[7]}}, byte_v};
      OP_LBU:  res = {24'h000000, byte_v};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mie_regfile.sv -----
// 32 x 32 register file with two registered read ports and reset-clear valid bits
`default_nettype none

module mie_regfile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  logic [4:0]  rd_a_addr_i,
  input  logic [4:0]  rd_b_addr_i,
  output logic [31:0] rd_a_data_o,
  output logic [31:0] rd_b_data_o,
  input  logic        wr_en_i,
  input  logic [4:0]  wr_addr_i,
  input  logic [31:0] wr_data_i
);
  import mie_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] vld_q;
  logic [31:0] rd_a_q, rd_b_q;
  logic        rd_a_vld_q, rd_b_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_a_addr_i];
      rd_b_q <= mem[rd_b_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_a_vld_q <= vld_q[rd_a_addr_i];
        rd_b_vld_q <= vld_q[rd_b_addr_i];
      end
    end
  end

  // never-written registers read as zero
  assign rd_a_data_o = rd_a_vld_q ? rd_a_q : '0;
  assign rd_b_data_o = rd_b_vld_q ? rd_b_q : '0;

endmodule

`default_nettype wire

// ----- rtl/mie_dmem.sv -----
// data memory as four byte lanes of words, with a clearing pass after reset
`default_nettype none

module mie_dmem #(
  parameter int MEM_BYTES = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  output logic                                   clr_busy_o,
  input  logic                                   rd_en_i,
  input  logic [$clog2((MEM_BYTES + 3) / 4)-1:0] rd_row_i,
  output logic [31:0]                            rd_data_o,
  input  logic [3:0]                             wr_be_i,
  input  logic [$clog2((MEM_BYTES + 3) / 4)-1:0] wr_row_i,
  input  logic [31:0]                            wr_data_i
);
  import mie_pkg::*;

  localparam int Rows = (MEM_BYTES + 3) / 4;
  localparam int RowW = $clog2(Rows);

  // lane 0 holds the lowest byte address of a row, i.e. the most significant byte
  logic [7:0] lane0 [Rows];
  logic [7:0] lane1 [Rows];
  logic [7:0] lane2 [Rows];
  logic [7:0] lane3 [Rows];

  logic            clr_q;
  logic [RowW-1:0] cnt_q;
  logic [3:0]      be;
  logic [RowW-1:0] row;
  logic [31:0]     wdata;

  always_comb begin
    if (clr_q) begin
      be    = 4'b1111;
      row   = cnt_q;
      wdata = '0;
    end else begin
      be    = wr_be_i;
      row   = wr_row_i;
      wdata = wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be[3]) lane0[row] <= wdata[31:24];
    if (be[2]) lane1[row] <= wdata[23:16];
    if (be[1]) lane2[row] <= wdata[15:8];
    if (be[0]) lane3[row] <= wdata[7:0];
    if (rd_en_i) begin
      rd_data_o <= {lane0[rd_row_i], lane1[rd_row_i], lane2[rd_row_i], lane3[rd_row_i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else if (clr_q) begin
      if (cnt_q == RowW'(Rows - 1)) begin
        clr_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign clr_busy_o = clr_q;

endmodule

`default_nettype wire

// ----- rtl/mie_alu.sv -----
// execute logic: alu, address checks, branch target and store lane steering
`default_nettype none

module mie_alu #(
  parameter int MEM_BYTES = 1024
) (
  input  mie_pkg::op_e   op_i,
  input  logic [4:0]     rt_index_i,
  input  logic [15:0]    immediate_i,
  input  logic [31:0]    rs_val_i,
  input  logic [31:0]    rt_val_i,
  input  logic [31:0]    pc_i,
  output mie_pkg::exec_t exec_o
);
  import mie_pkg::*;

  localparam logic [32:0] MemLimit = 33'(MEM_BYTES);

  logic [31:0] simm;
  logic [31:0] sum;
  logic        sum_ovf;
  logic [2:0]  size;
  logic        is_mem, is_load;
  logic        aerr, merr, ok;
  logic [1:0]  off;
  logic [31:0] val;
  logic        wr;
  logic        taken;

  always_comb begin
    simm    = {{16{immediate_i[15]}}, immediate_i};
    sum     = rs_val_i + simm;
    sum_ovf = ~(rs_val_i[31] ^ simm[31]) & (rs_val_i[31] ^ sum[31]);
    off     = sum[1:0];

    case (op_i)
      OP_LW, OP_SW:        size = 3'd4;
      OP_LH, OP_LHU, OP_SH: size = 3'd2;
      default:             size = 3'd1;
    endcase
    is_mem  = (op_i inside {[OP_LW:OP_SB]});
    is_load = (op_i inside {[OP_LW:OP_LBU]});
    aerr    = is_mem && (({1'b0, sum} + 33'(size)) > MemLimit);
    merr    = is_mem && ((sum[1:0] & (size[1:0] - 2'd1)) != 2'b00);
    ok      = !sum_ovf && !aerr && !merr;

    val   = '0;
    wr    = 1'b1;
    taken = 1'b0;
    case (op_i)
      OP_ADDI: begin
        val = sum;
        wr  = !sum_ovf;
      end
      OP_LUI:  val = {immediate_i, 16'h0000};
      OP_ANDI: val = rs_val_i & {16'h0000, immediate_i};
      OP_ORI:  val = rs_val_i | {16'h0000, immediate_i};
      OP_NORI: val = ~(rs_val_i | {16'h0000, immediate_i});
      OP_SLTI: val = {31'd0, $signed(rs_val_i) < $signed(simm)};
      OP_BEQ: begin
        wr    = 1'b0;
        taken = (rs_val_i == rt_val_i);
      end
      OP_BNE: begin
        wr    = 1'b0;
        taken = (rs_val_i != rt_val_i);
      end
      default: wr = 1'b0; // loads write later, stores never
    endcase

    exec_o.reg_wr   = wr && (rt_index_i != 5'd0);
    exec_o.reg_val  = val;
    exec_o.ovf      = (op_i == OP_ADDI || is_mem) && sum_ovf;
    exec_o.aerr     = aerr;
    exec_o.merr     = merr;
    exec_o.taken    = taken;
    exec_o.next_pc  = taken ? pc_i + {simm[29:0], 2'b00} : pc_i;
    exec_o.load_go  = is_load && ok;
    exec_o.addr     = sum;

    // big-endian: byte address offset 0 sits in the top lane
    exec_o.store_we   = 4'b0000;
    exec_o.store_data = '0;
    if (ok) begin
      case (op_i)
        OP_SW: begin
          exec_o.store_we   = 4'b1111;
          exec_o.store_data = rt_val_i;
        end
        OP_SH: begin
          exec_o.store_we   = off[1] ? 4'b0011 : 4'b1100;
          exec_o.store_data = {2{rt_val_i[15:0]}};
        end
        OP_SB: begin
          exec_o.store_we   = 4'b1000 >> off;
          exec_o.store_data = {4{rt_val_i[7:0]}};
        end
        default: begin
          exec_o.store_we   = 4'b0000;
          exec_o.store_data = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mips_itype_execute_top.sv -----
// top level of the mips i-type execute block
`default_nettype none

// Executes one decoded I-type instruction per input transaction against a
// 32 x 32 register file, a big-endian byte-addressed data memory of MEM_BYTES
// bytes and a program counter, and returns one result transaction per
// instruction. An instruction passes through a register file read, then the
// execute cycle that writes the register file or the data memory. Loads add a
// registered read of the data memory before the register file write. Only
// one instruction is in flight; a finished result waits in the output register
// while the next instruction is already accepted. If that register is still
// stalled when the next result is done, the new result parks and input stays
// stalled until the output register frees. After reset the data memory is
// zeroed one 4-byte row per cycle, and input is stalled until that clearing
// pass is done.
module mips_itype_execute_top #(
  parameter int MEM_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  op_i,
  input  logic [4:0]  rs_index_i,
  input  logic [4:0]  rt_index_i,
  input  logic [15:0] immediate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic        branch_taken_o,
  output logic        reg_write_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic        overflow_flag_o,
  output logic        address_error_o,
  output logic        misaligned_error_o
);
  import mie_pkg::*;

  localparam int Rows = (MEM_BYTES + 3) / 4;
  localparam int RowW = $clog2(Rows);

  state_e      state_q, state_d;
  op_e         op_q;
  logic [4:0]  rt_q;
  logic [15:0] imm_q;
  logic [1:0]  off_q;
  logic [31:0] pc_q;
  result_t     out_q, hold_q, res;
  logic        out_valid_q;

  logic        accept, out_free, fin;
  logic        rf_rd_en;
  logic [31:0] rs_val, rt_val;
  logic        rf_we;
  logic [31:0] rf_wd;
  logic        clr_busy;
  logic [31:0] mem_rdata;
  logic [31:0] load_val;
  logic        load_wr;
  exec_t       ex;

  mie_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rf_rd_en),
    .rd_a_addr_i (rs_index_i),
    .rd_b_addr_i (rt_index_i),
    .rd_a_data_o (rs_val),
    .rd_b_data_o (rt_val),
    .wr_en_i     (rf_we),
    .wr_addr_i   (rt_q),
    .wr_data_i   (rf_wd)
  );

  mie_alu #(
    .MEM_BYTES (MEM_BYTES)
  ) u_alu (
    .op_i        (op_q),
    .rt_index_i  (rt_q),
    .immediate_i (imm_q),
    .rs_val_i    (rs_val),
    .rt_val_i    (rt_val),
    .pc_i        (pc_q),
    .exec_o      (ex)
  );

  mie_dmem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_busy_o (clr_busy),
    .rd_en_i    (state_q == S_EXEC && ex.load_go),
    .rd_row_i   (ex.addr[RowW+1:2]),
    .rd_data_o  (mem_rdata),
    .wr_be_i    ((state_q == S_EXEC) ? ex.store_we : 4'b0000),
    .wr_row_i   (ex.addr[RowW+1:2]),
    .wr_data_i  (ex.store_data)
  );

  assign load_val = load_extract(op_q, off_q, mem_rdata);
  assign load_wr  = (rt_q != 5'd0);
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    rf_rd_en   = 1'b0;
    rf_we      = 1'b0;
    rf_wd      = ex.reg_val;
    fin        = 1'b0;
    res        = hold_q;
    case (state_q)
      S_CLEAR: begin
        if (!clr_busy) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        rf_rd_en   = 1'b1;
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        rf_we = ex.reg_wr;
        if (ex.load_go) begin
          state_d = S_LOAD;
        end else begin
          fin                  = 1'b1;
          res.next_pc          = ex.next_pc;
          res.branch_taken     = ex.taken;
          res.reg_write        = ex.reg_wr;
          res.reg_index        = ex.reg_wr ? rt_q : 5'd0;
          res.reg_value        = ex.reg_wr ? ex.reg_val : '0;
          res.overflow_flag    = ex.ovf;
          res.address_error    = ex.aerr;
          res.misaligned_error = ex.merr;
        end
      end
      S_LOAD: begin
        rf_we                = load_wr;
        rf_wd                = load_val;
        fin                  = 1'b1;
        res.next_pc          = pc_q;
        res.branch_taken     = 1'b0;
        res.reg_write        = load_wr;
        res.reg_index        = rt_q;
        res.reg_value        = load_wr ? load_val : '0;
        res.overflow_flag    = 1'b0;
        res.address_error    = 1'b0;
        res.misaligned_error = 1'b0;
      end
      S_HOLD: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
    if (fin) begin
      state_d = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC && ex.taken) begin
        pc_q <= ex.next_pc;
      end
      if ((fin || state_q == S_HOLD) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(op_i);
      rt_q  <= rt_index_i;
      imm_q <= immediate_i;
    end
    if (state_q == S_EXEC) begin
      off_q <= ex.addr[1:0];
    end
    // result parks here while the previous one is still stalled
    if (fin && !out_free) begin
      hold_q <= res;
    end
    if ((fin || state_q == S_HOLD) && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign next_pc_o          = out_q.next_pc;
  assign branch_taken_o     = out_q.branch_taken;
  assign reg_write_o        = out_q.reg_write;
  assign reg_index_o        = out_q.reg_index;
  assign reg_value_o        = out_q.reg_value;
  assign overflow_flag_o    = out_q.overflow_flag;
  assign address_error_o    = out_q.address_error;
  assign misaligned_error_o = out_q.misaligned_error;

  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted transaction did not enter execute");

  a_no_r0_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.reg_write && out_q.reg_index == 5'd0))
    else $error("result reports a write to register zero");

  a_error_suppresses : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.address_error || out_q.misaligned_error || out_q.overflow_flag)
      |-> !out_q.reg_write)
    else $error("flagged access still wrote a register");

  a_no_write_zero_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.reg_write |-> out_q.reg_value == 32'd0 && out_q.reg_index == 5'd0)
    else $error("register payload not cleared without a write");

endmodule

`default_nettype wire

// ----- sim/mie_result_checker.sv -----
// checker for the i-type execute block: predicts each result and compares it with the output
module mie_result_checker
  import mie_pkg::*;
#(
  parameter int MEM_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [3:0]  op_i,
  input  logic [4:0]  rs_index_i,
  input  logic [4:0]  rt_index_i,
  input  logic [15:0] immediate_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] next_pc_i,
  input  logic        branch_taken_i,
  input  logic        reg_write_i,
  input  logic [4:0]  reg_index_i,
  input  logic [31:0] reg_value_i,
  input  logic        overflow_flag_i,
  input  logic        address_error_i,
  input  logic        misaligned_error_i,
  output int          mismatch_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] gpr [32];
  logic [7:0]  dmem [MEM_BYTES];
  logic [31:0] pc_q;
  result_t     expected_results[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          pending_q = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending_q;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("%0t ns result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  // executes one instruction on the local copy of the state
  task automatic execute_instr(input op_e op, input logic [4:0] rs, input logic [4:0] rt,
                               input logic [15:0] imm, output result_t res);
    logic [31:0] simm, src, tgt, sum, value;
    logic        ovf, do_write;
    int unsigned nbytes;
    simm     = {{16{imm[15]}}, imm};
    src      = gpr[rs];
    tgt      = gpr[rt];
    sum      = src + simm;
    ovf      = (src[31] == simm[31]) && (sum[31] != src[31]);
    value    = '0;
    do_write = 1'b0;
    res      = '0;
    case (op)
      OP_ADDI: begin
        res.overflow_flag = ovf;
        value    = sum;
        do_write = !ovf;
      end
      OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB: begin
        if (op == OP_LW || op == OP_SW) nbytes = 4;
        else if (op == OP_LH || op == OP_LHU || op == OP_SH) nbytes = 2;
        else nbytes = 1;
        res.overflow_flag    = ovf;
        res.address_error    = (64'(sum) + 64'(nbytes)) > 64'(MEM_BYTES);
        res.misaligned_error = (sum & (nbytes - 1)) != 0;
        // any flag suppresses the access, stores included
        if (!(res.overflow_flag || res.address_error || res.misaligned_error)) begin
          if (op <= OP_LBU) begin
            for (int i = 0; i < nbytes; i++) value = {value[23:0], dmem[sum + i]};
            if (op == OP_LH) value = {{16{value[15]}}, value[15:0]};
            else if (op == OP_LB) value = {{24{value[7]}}, value[7:0]};
            do_write = 1'b1;
          end else begin
            for (int i = 0; i < nbytes; i++) dmem[sum + i] = 8'(tgt >> (8 * (nbytes - 1 - i)));
          end
        end
      end
      OP_LUI: begin
        value    = {imm, 16'h0000};
        do_write = 1'b1;
      end
      OP_ANDI: begin
        value    = src & {16'h0000, imm};
        do_write = 1'b1;
      end
      OP_ORI: begin
        value    = src | {16'h0000, imm};
        do_write = 1'b1;
      end
      OP_NORI: begin
        value    = ~(src | {16'h0000, imm});
        do_write = 1'b1;
      end
      OP_SLTI: begin
        value    = ($signed(src) < $signed(simm)) ? 32'd1 : 32'd0;
        do_write = 1'b1;
      end
      default: begin
        res.branch_taken = (op == OP_BEQ) ? (src == tgt) : (src != tgt);
        if (res.branch_taken) pc_q = pc_q + (simm << 2);
      end
    endcase
    // register zero never changes
    if (do_write && rt != 5'd0) begin
      gpr[rt]       = value;
      res.reg_write = 1'b1;
      res.reg_index = rt;
      res.reg_value = value;
    end
    res.next_pc = pc_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      for (int i = 0; i < MEM_BYTES; i++) dmem[i] = '0;
      pc_q = '0;
      expected_results.delete();
      pending_q <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {next_pc_i, branch_taken_i, reg_write_i, reg_index_i, reg_value_i,
               overflow_flag_i, address_error_i, misaligned_error_i};
        if (expected_results.size() == 0) begin
          report_mismatch("result with no instruction outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("next_pc", got.next_pc, want.next_pc);
          check_field("branch_taken", got.branch_taken, want.branch_taken);
          check_field("reg_write", got.reg_write, want.reg_write);
          check_field("reg_index", got.reg_index, want.reg_index);
          check_field("reg_value", got.reg_value, want.reg_value);
          check_field("overflow_flag", got.overflow_flag, want.overflow_flag);
          check_field("address_error", got.address_error, want.address_error);
          check_field("misaligned_error", got.misaligned_error, want.misaligned_error);
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i) begin
        execute_instr(op_e'(op_i), rs_index_i, rt_index_i, immediate_i, want);
        expected_results.push_back(want);
      end
      pending_q <= expected_results.size();
    end
  end

endmodule

// ----- sim/tb_mips_itype_execute_top.sv -----
// testbench top for the i-type execute block: clock, reset, stimulus and verdict
module tb_mips_itype_execute_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mie_pkg::*;

  localparam int MEM_BYTES    = 1024;
  localparam int RANDOM_ITEMS = 600;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 12;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  op_i = '0;
  logic [4:0]  rs_index_i = '0;
  logic [4:0]  rt_index_i = '0;
  logic [15:0] immediate_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] next_pc_o;
  logic        branch_taken_o;
  logic        reg_write_o;
  logic [4:0]  reg_index_o;
  logic [31:0] reg_value_o;
  logic        overflow_flag_o;
  logic        address_error_o;
  logic        misaligned_error_o;

  int          mismatch_count;
  int          pending;
  int          burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_phase = 0;

  mips_itype_execute_top #(
    .MEM_BYTES(MEM_BYTES)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .rs_index_i        (rs_index_i),
    .rt_index_i        (rt_index_i),
    .immediate_i       (immediate_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .next_pc_o         (next_pc_o),
    .branch_taken_o    (branch_taken_o),
    .reg_write_o       (reg_write_o),
    .reg_index_o       (reg_index_o),
    .reg_value_o       (reg_value_o),
    .overflow_flag_o   (overflow_flag_o),
    .address_error_o   (address_error_o),
    .misaligned_error_o(misaligned_error_o)
  );

  mie_result_checker #(
    .MEM_BYTES(MEM_BYTES)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .op_i              (op_i),
    .rs_index_i        (rs_index_i),
    .rt_index_i        (rt_index_i),
    .immediate_i       (immediate_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .next_pc_i         (next_pc_o),
    .branch_taken_i    (branch_taken_o),
    .reg_write_i       (reg_write_o),
    .reg_index_i       (reg_index_o),
    .reg_value_i       (reg_value_o),
    .overflow_flag_i   (overflow_flag_o),
    .address_error_i   (address_error_o),
    .misaligned_error_i(misaligned_error_o),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls follow a mode that is redrawn at random whenever its phase count runs out
  always @(posedge clk_i) begin
    if (stall_phase == 0) begin
      stall_mode  <= stall_mode_e'($urandom_range(STALL_NONE, STALL_HEAVY));
      stall_phase <= $urandom_range(20, 80);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall_i <= (stall_phase % 3 == 0);
      default:        out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // one instruction transaction, with a random gap before each new burst
  task automatic send_instr(input op_e op, input logic [4:0] rs, input logic [4:0] rt,
                            input logic [15:0] imm);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    op_i        <= op;
    rs_index_i  <= rs;
    rt_index_i  <= rt;
    immediate_i <= imm;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    op_e         op;
    logic [4:0]  rs, rt;
    logic [15:0] imm;
    int          kind;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_instr(OP_LUI, 5'd0, 5'd1, 16'h8000);
    send_instr(OP_LUI, 5'd5, 5'd0, 16'hFFFF);   // write to register zero is dropped
    send_instr(OP_ADDI, 5'd1, 5'd2, 16'hFFFF);  // negative overflow
    send_instr(OP_LUI, 5'd0, 5'd3, 16'h7FFF);
    send_instr(OP_ORI, 5'd3, 5'd3, 16'hFFFF);
    send_instr(OP_ADDI, 5'd3, 5'd4, 16'h0001);  // positive overflow
    send_instr(OP_ADDI, 5'd0, 5'd5, 16'h7FFF);
    send_instr(OP_ADDI, 5'd0, 5'd6, 16'h8000);
    send_instr(OP_SW, 5'd0, 5'd1, 16'h0000);
    send_instr(OP_SW, 5'd0, 5'd3, 16'h0004);
    send_instr(OP_LW, 5'd0, 5'd7, 16'h0004);
    send_instr(OP_LH, 5'd0, 5'd8, 16'h0000);
    send_instr(OP_LHU, 5'd0, 5'd9, 16'h0000);
    send_instr(OP_LB, 5'd0, 5'd10, 16'h0000);
    send_instr(OP_LBU, 5'd0, 5'd11, 16'h0007);
    send_instr(OP_SH, 5'd0, 5'd6, 16'(MEM_BYTES - 2));
    send_instr(OP_SB, 5'd0, 5'd6, 16'h0009);
    send_instr(OP_LW, 5'd0, 5'd12, 16'h0002);   // misaligned load
    send_instr(OP_SH, 5'd0, 5'd5, 16'h0001);    // misaligned store
    send_instr(OP_LW, 5'd0, 5'd13, 16'(MEM_BYTES));
    send_instr(OP_SB, 5'd0, 5'd5, 16'hFFFF);    // address wraps below zero
    send_instr(OP_LB, 5'd1, 5'd14, 16'hFFFF);   // address sum overflows
    send_instr(OP_ANDI, 5'd3, 5'd15, 16'hA5A5);
    send_instr(OP_NORI, 5'd0, 5'd16, 16'h0000);
    send_instr(OP_SLTI, 5'd6, 5'd17, 16'h0000);
    send_instr(OP_BEQ, 5'd0, 5'd0, 16'hFFFF);   // pc wraps backward
    send_instr(OP_BNE, 5'd1, 5'd0, 16'h0001);
    send_instr(OP_BNE, 5'd0, 5'd0, 16'h7FFF);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 9);
      rs   = 5'($urandom_range(0, 31));
      rt   = 5'($urandom_range(0, 31));
      imm  = 16'($urandom_range(0, 16'hFFFF));
      if (kind < 4) begin
        op = op_e'($urandom_range(OP_LW, OP_SB));
        // mostly legal accesses, half of them crowded into a small window so loads see stores
        if (kind < 3) begin
          rs  = '0;
          imm = $urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                     : 16'($urandom_range(0, MEM_BYTES - 1));
          if (op == OP_LW || op == OP_SW) imm[1:0] = 2'b00;
          else if (op == OP_LH || op == OP_LHU || op == OP_SH) imm[0] = 1'b0;
        end
      end else if (kind < 6) begin
        op = op_e'($urandom_range(OP_LUI, OP_SLTI));
      end else if (kind == 6) begin
        op = OP_ADDI;
      end else if (kind == 7) begin
        op = op_e'($urandom_range(OP_BEQ, OP_BNE));
      end else begin
        op = op_e'($urandom_range(OP_ADDI, OP_BNE));
      end
      send_instr(op, rs, rt, imm);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mie_pkg.sv
rtl/mie_regfile.sv
rtl/mie_dmem.sv
rtl/mie_alu.sv
rtl/mips_itype_execute_top.sv
sim/mie_result_checker.sv
sim/tb_mips_itype_execute_top.sv
